// ===== rtl/qfhi_pkg.sv =====
// Shared constants, widths and types for the quad face height interpolator.
// No dependencies; every other file imports this package.
package qfhi_pkg;

  localparam int FACE_COUNT   = 1024;
  localparam int WIDEN_FACTOR = 268;
  localparam int FACE_AW      = (FACE_COUNT > 1) ? $clog2(FACE_COUNT) : 1;

  localparam int CW = 16;  // corner and query coordinates
  localparam int WW = 19;  // widened corner coordinates
  localparam int DW = 20;  // edge vectors
  localparam int PW = 40;  // edge products
  localparam int TW = 41;  // numerators and denominator
  localparam int QW = 18;  // quotient bits kept (values below 4.0 in 16.16)

  localparam logic [16:0] ONE_FX = 17'h10000;
  localparam int ZERO_BOT_SUB = 'h8000;
  localparam int MIN_BOT      = 3;

  localparam int GEOM_LAT = 6;
  localparam int OUT_LAT  = 4;
  localparam int LAT      = 1 + GEOM_LAT + QW + OUT_LAT;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;

  typedef struct packed {
    logic den_low; // denominator below the minimum
    logic neg_a;
    logic neg_b;
    logic ovf_a;   // quotient at or above 4.0
    logic ovf_b;
  } tri_flags_t;

  typedef struct packed {
    logic [TW-1:0] den;
    logic [TW-1:0] num_a;
    logic [TW-1:0] num_b;
  } tri_div_t;

  typedef struct packed {
    logic              valid;
    logic              face_ok;
    logic              flat;
    logic [3:0][CW-1:0] vy;
    tri_flags_t        t0;
    tri_flags_t        t1;
  } side_t;

endpackage

// ===== rtl/qfhi_corner_mem.sv =====
// Corner store: one bank per corner so a query reads all four in the same cycle.
// Depends on qfhi_pkg. Registered read, contents undefined until written.
module qfhi_corner_mem
  import qfhi_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [1:0]         wr_corner_i,
  input  logic [FACE_AW-1:0] wr_face_i,
  input  vert_t              wr_data_i,
  input  logic [FACE_AW-1:0] rd_face_i,
  output vert_t [3:0]        rd_data_o
);

  for (genvar c = 0; c < 4; c++) begin : g_bank
    vert_t mem_q [FACE_COUNT];
    vert_t rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wr_corner_i == 2'(c))) begin
        mem_q[wr_face_i] <= wr_data_i;
      end
      rd_q <= mem_q[rd_face_i];
    end

    assign rd_data_o[c] = rd_q;
  end

endmodule

// ===== rtl/qfhi_geom.sv =====
// Geometry pipeline: centroid, widening, edge vectors, cross products and
// divider setup for both triangles. Depends on qfhi_pkg.
module qfhi_geom
  import qfhi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        face_ok_i,
  input  coord_t      qx_i,
  input  coord_t      qz_i,
  input  vert_t [3:0] vert_i,
  output side_t       side_o,
  output tri_div_t    div0_o,
  output tri_div_t    div1_o
);

  logic [GEOM_LAT-1:0] vld_q;
  logic [GEOM_LAT-1:0] ok_q;
  logic [GEOM_LAT-1:0] flat_q;
  logic [3:0][CW-1:0]  vy_q [GEOM_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[GEOM_LAT-2:0], valid_i};
    end
  end

  // stage 1: centroid and flat test
  logic signed [CW+1:0] sx_d, sz_d;
  logic                 flat_d;
  coord_t g1_mx_q, g1_mz_q, g1_qx_q, g1_qz_q;
  coord_t g1_vx_q [4];
  coord_t g1_vz_q [4];

  always_comb begin
    sx_d = (CW+2)'(vert_i[0].x) + (CW+2)'(vert_i[1].x)
         + (CW+2)'(vert_i[2].x) + (CW+2)'(vert_i[3].x);
    sz_d = (CW+2)'(vert_i[0].z) + (CW+2)'(vert_i[1].z)
         + (CW+2)'(vert_i[2].z) + (CW+2)'(vert_i[3].z);
    flat_d = (vert_i[0].y == vert_i[1].y) && (vert_i[1].y == vert_i[2].y)
          && (vert_i[2].y == vert_i[3].y);
  end

  always_ff @(posedge clk_i) begin
    g1_mx_q   <= sx_d[CW+1:2];
    g1_mz_q   <= sz_d[CW+1:2];
    g1_qx_q   <= qx_i;
    g1_qz_q   <= qz_i;
    ok_q[0]   <= face_ok_i;
    flat_q[0] <= flat_d;
    for (int c = 0; c < 4; c++) begin
      g1_vx_q[c]   <= vert_i[c].x;
      g1_vz_q[c]   <= vert_i[c].z;
      vy_q[0][c]   <= vert_i[c].y;
    end
    for (int s = 1; s < GEOM_LAT; s++) begin
      ok_q[s]   <= ok_q[s-1];
      flat_q[s] <= flat_q[s-1];
      vy_q[s]   <= vy_q[s-1];
    end
  end

  // stage 2: widen about the centroid
  logic signed [WW-1:0] wx_d [4];
  logic signed [WW-1:0] wz_d [4];
  logic signed [WW-1:0] g2_wx_q [4];
  logic signed [WW-1:0] g2_wz_q [4];
  coord_t g2_qx_q, g2_qz_q;

  always_comb begin
    logic signed [31:0] tx, tz;
    for (int c = 0; c < 4; c++) begin
      tx = (32'(g1_vx_q[c]) - 32'(g1_mx_q)) * 32'(WIDEN_FACTOR);
      tz = (32'(g1_vz_q[c]) - 32'(g1_mz_q)) * 32'(WIDEN_FACTOR);
      wx_d[c] = WW'((tx >>> 8) + 32'(g1_mx_q));
      wz_d[c] = WW'((tz >>> 8) + 32'(g1_mz_q));
    end
  end

  always_ff @(posedge clk_i) begin
    g2_wx_q <= wx_d;
    g2_wz_q <= wz_d;
    g2_qx_q <= g1_qx_q;
    g2_qz_q <= g1_qz_q;
  end

  // stage 3: edge vectors; triangle 0 is (0,1,2), triangle 1 is (3,2,1)
  // order per triangle: ax, az, bx, bz, x, z
  logic signed [DW-1:0] ev_d [2][6];
  logic signed [DW-1:0] g3_ev_q [2][6];

  always_comb begin
    int o, i, j;
    for (int t = 0; t < 2; t++) begin
      o = (t == 0) ? 0 : 3;
      i = (t == 0) ? 1 : 2;
      j = (t == 0) ? 2 : 1;
      ev_d[t][0] = DW'(g2_wx_q[i]) - DW'(g2_wx_q[o]);
      ev_d[t][1] = DW'(g2_wz_q[i]) - DW'(g2_wz_q[o]);
      ev_d[t][2] = DW'(g2_wx_q[j]) - DW'(g2_wx_q[o]);
      ev_d[t][3] = DW'(g2_wz_q[j]) - DW'(g2_wz_q[o]);
      ev_d[t][4] = DW'(g2_qx_q) - DW'(g2_wx_q[o]);
      ev_d[t][5] = DW'(g2_qz_q) - DW'(g2_wz_q[o]);
    end
  end

  always_ff @(posedge clk_i) begin
    g3_ev_q <= ev_d;
  end

  // stage 4: products. The 8.8 scaling cancels the >>16, so these are exact.
  logic signed [PW-1:0] g4_p_q [2][6];

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 2; t++) begin
      g4_p_q[t][0] <= g3_ev_q[t][4] * g3_ev_q[t][3];  // x*bz
      g4_p_q[t][1] <= g3_ev_q[t][5] * g3_ev_q[t][2];  // z*bx
      g4_p_q[t][2] <= g3_ev_q[t][3] * g3_ev_q[t][0];  // bz*ax
      g4_p_q[t][3] <= g3_ev_q[t][2] * g3_ev_q[t][1];  // bx*az
      g4_p_q[t][4] <= g3_ev_q[t][5] * g3_ev_q[t][0];  // z*ax
      g4_p_q[t][5] <= g3_ev_q[t][4] * g3_ev_q[t][1];  // x*az
    end
  end

  // stage 5: numerators and denominator
  logic signed [TW-1:0] g5_ta_q [2];
  logic signed [TW-1:0] g5_tb_q [2];
  logic signed [TW-1:0] g5_bot_q [2];

  always_ff @(posedge clk_i) begin
    logic signed [TW-1:0] bot;
    for (int t = 0; t < 2; t++) begin
      bot = TW'(g4_p_q[t][2]) - TW'(g4_p_q[t][3]);
      g5_ta_q[t]  <= TW'(g4_p_q[t][0]) - TW'(g4_p_q[t][1]);
      g5_tb_q[t]  <= TW'(g4_p_q[t][4]) - TW'(g4_p_q[t][5]);
      g5_bot_q[t] <= (bot == '0) ? TW'(ZERO_BOT_SUB) : bot;
    end
  end

  // stage 6: sign/magnitude split and range checks for the dividers
  tri_flags_t fl_d [2];
  tri_div_t   dv_d [2];
  tri_flags_t g6_fl_q [2];
  tri_div_t   g6_dv_q [2];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      fl_d[t].den_low = g5_bot_q[t] < TW'(MIN_BOT);
      fl_d[t].neg_a   = g5_ta_q[t][TW-1];
      fl_d[t].neg_b   = g5_tb_q[t][TW-1];
      dv_d[t].den     = g5_bot_q[t];
      dv_d[t].num_a   = fl_d[t].neg_a ? -g5_ta_q[t] : g5_ta_q[t];
      dv_d[t].num_b   = fl_d[t].neg_b ? -g5_tb_q[t] : g5_tb_q[t];
      fl_d[t].ovf_a   = {2'b00, dv_d[t].num_a[TW-1:2]} >= dv_d[t].den;
      fl_d[t].ovf_b   = {2'b00, dv_d[t].num_b[TW-1:2]} >= dv_d[t].den;
    end
  end

  always_ff @(posedge clk_i) begin
    g6_fl_q <= fl_d;
    g6_dv_q <= dv_d;
  end

  always_comb begin
    side_o.valid   = vld_q[GEOM_LAT-1];
    side_o.face_ok = ok_q[GEOM_LAT-1];
    side_o.flat    = flat_q[GEOM_LAT-1];
    side_o.vy      = vy_q[GEOM_LAT-1];
    side_o.t0      = g6_fl_q[0];
    side_o.t1      = g6_fl_q[1];
  end

  assign div0_o = g6_dv_q[0];
  assign div1_o = g6_dv_q[1];

endmodule

// ===== rtl/qfhi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^16 / den) when num < 4*den. Depends on qfhi_pkg.
module qfhi_div
  import qfhi_pkg::*;
(
  input  logic          clk_i,
  input  logic [TW-1:0] num_i,
  input  logic [TW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [TW-1:0] rem_q [QW];
  logic [TW-1:0] den_q [QW];
  logic [1:0]    lo_q  [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [TW-1:0] rem_in, den_in;
    logic [1:0]    lo_in;
    logic [QW-1:0] quo_in;
    logic [TW:0]   shf, dif;

    if (s == 0) begin : g_first
      // dividend bits: num[TW-1:2] seed the remainder, num[1:0] then zeros
      assign rem_in = {2'b00, num_i[TW-1:2]};
      assign den_in = den_i;
      assign lo_in  = num_i[1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign shf = {rem_in, lo_in[1]};
    assign dif = shf - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[s] <= dif[TW] ? shf[TW-1:0] : dif[TW-1:0];
      quo_q[s] <= {quo_in[QW-2:0], ~dif[TW]};
      den_q[s] <= den_in;
      lo_q[s]  <= {lo_in[0], 1'b0};
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== rtl/qfhi_interp.sv =====
// Output pipeline: clamp alpha/beta, pick triangle or fallback corner,
// interpolate the height and saturate. Depends on qfhi_pkg.
module qfhi_interp
  import qfhi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  side_t         side_i,
  input  logic [QW-1:0] q0a_i,
  input  logic [QW-1:0] q0b_i,
  input  logic [QW-1:0] q1a_i,
  input  logic [QW-1:0] q1b_i,
  output logic          done_o,
  output coord_t        height_o,
  output logic          on_face_o
);

  // returns {cleared, value}
  function automatic logic [17:0] clamp_fx(input logic neg, input logic ovf,
                                           input logic [QW-1:0] q);
    logic       clr;
    logic [16:0] v;
    if (neg) begin
      v   = '0;
      clr = ovf || (q != '0);
    end else if (ovf || (q > QW'(ONE_FX))) begin
      v   = ONE_FX;
      clr = 1'b1;
    end else begin
      v   = q[16:0];
      clr = 1'b0;
    end
    return {clr, v};
  endfunction

  logic [OUT_LAT-2:0] vld_q;

  // stage 1: clamp
  side_t       s1_side_q;
  logic [16:0] s1_al_q [2];
  logic [16:0] s1_be_q [2];
  logic        s1_clr_q [2];
  logic        s1_gt_q [2];

  always_ff @(posedge clk_i) begin
    logic [17:0] ca, cb;
    logic [QW-1:0] qa, qb;
    tri_flags_t f;
    for (int t = 0; t < 2; t++) begin
      f  = (t == 0) ? side_i.t0 : side_i.t1;
      qa = (t == 0) ? q0a_i : q1a_i;
      qb = (t == 0) ? q0b_i : q1b_i;
      ca = clamp_fx(f.neg_a, f.ovf_a, qa);
      cb = clamp_fx(f.neg_b, f.ovf_b, qb);
      s1_al_q[t]  <= ca[16:0];
      s1_be_q[t]  <= cb[16:0];
      s1_clr_q[t] <= ca[17] | cb[17];
      s1_gt_q[t]  <= ({1'b0, ca[16:0]} + {1'b0, cb[16:0]}) > {1'b0, ONE_FX};
    end
    s1_side_q <= side_i;
  end

  // stage 2: choose the result path
  logic                 s2_interp_q, s2_on_q;
  coord_t               s2_base_q;
  logic [16:0]          s2_al_q, s2_be_q;
  logic signed [CW:0]   s2_di_q, s2_dj_q;

  always_ff @(posedge clk_i) begin
    int o, i, j;
    logic use1;
    use1 = s1_gt_q[0];
    o = use1 ? 3 : 0;
    i = use1 ? 2 : 1;
    j = use1 ? 1 : 2;
    s2_al_q <= use1 ? s1_al_q[1] : s1_al_q[0];
    s2_be_q <= use1 ? s1_be_q[1] : s1_be_q[0];
    s2_di_q <= (CW+1)'($signed(s1_side_q.vy[i])) - (CW+1)'($signed(s1_side_q.vy[o]));
    s2_dj_q <= (CW+1)'($signed(s1_side_q.vy[j])) - (CW+1)'($signed(s1_side_q.vy[o]));
    s2_interp_q <= 1'b0;
    if (!s1_side_q.face_ok) begin
      s2_base_q <= '0;
      s2_on_q   <= 1'b0;
    end else if (s1_side_q.flat || s1_side_q.t0.den_low) begin
      s2_base_q <= s1_side_q.vy[0];
      s2_on_q   <= 1'b1;
    end else if (!s1_gt_q[0]) begin
      s2_base_q   <= s1_side_q.vy[0];
      s2_on_q     <= !s1_clr_q[0];
      s2_interp_q <= 1'b1;
    end else if (s1_side_q.t1.den_low) begin
      s2_base_q <= s1_side_q.vy[3];
      s2_on_q   <= !s1_clr_q[0];
    end else if (s1_gt_q[1]) begin
      s2_base_q <= s1_side_q.vy[1];
      s2_on_q   <= 1'b0;
    end else begin
      s2_base_q   <= s1_side_q.vy[3];
      s2_on_q     <= !(s1_clr_q[0] | s1_clr_q[1]);
      s2_interp_q <= 1'b1;
    end
  end

  // stage 3: weight products
  logic                s3_interp_q, s3_on_q;
  coord_t              s3_base_q;
  logic signed [34:0]  s3_pa_q, s3_pb_q;

  always_ff @(posedge clk_i) begin
    s3_pa_q     <= $signed({1'b0, s2_al_q}) * s2_di_q;
    s3_pb_q     <= $signed({1'b0, s2_be_q}) * s2_dj_q;
    s3_base_q   <= s2_base_q;
    s3_on_q     <= s2_on_q;
    s3_interp_q <= s2_interp_q;
  end

  // stage 4: sum in 8.8, back to integer, saturate
  logic signed [28:0] y_d, ys_d;
  coord_t             h_d;
  coord_t             height_q;
  logic               on_q;

  always_comb begin
    y_d  = (29'(s3_base_q) <<< 8) + 29'(s3_pa_q >>> 8) + 29'(s3_pb_q >>> 8);
    ys_d = y_d >>> 8;
    if (!s3_interp_q) begin
      h_d = s3_base_q;
    end else if (ys_d > 29'sd32767) begin
      h_d = 16'sh7fff;
    end else if (ys_d < -29'sd32768) begin
      h_d = 16'sh8000;
    end else begin
      h_d = ys_d[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= h_d;
    on_q     <= s3_on_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[OUT_LAT-3:0], side_i.valid};
      done_o <= vld_q[OUT_LAT-2];
    end
  end

  assign height_o  = height_q;
  assign on_face_o = on_q;

endmodule

// ===== rtl/quad_face_height_interpolator.sv =====
// Quad face height interpolator: a pipelined barycentric height lookup on a
// four-corner face with a corner store and 18-stage dividers, taking one
// request per clock. busy_o stays low: the pipeline never stalls, since the
// receiver takes every result. A request with func_i low writes one corner
// and returns nothing; with func_i high it queries the face and returns
// height_o and on_face_o with done_o high for one cycle, results in request
// order. A write is seen by a query accepted in the next cycle. The store
// has no reset: reading a corner never written gives undefined fields.
// Depends on qfhi_pkg, qfhi_corner_mem, qfhi_geom, qfhi_div, qfhi_interp.
module quad_face_height_interpolator
  import qfhi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [9:0]  face_i,
  input  logic [1:0]  corner_i,
  input  coord_t      vert_x_i,
  input  coord_t      vert_y_i,
  input  coord_t      vert_z_i,
  input  coord_t      query_x_i,
  input  coord_t      query_z_i,
  output logic        done_o,
  output coord_t      height_o,
  output logic        on_face_o
);

  logic        accept, face_ok;
  vert_t       wr_data;
  vert_t [3:0] rd_data;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign face_ok = 32'(face_i) < FACE_COUNT;
  assign wr_data = '{x: vert_x_i, y: vert_y_i, z: vert_z_i};

  qfhi_corner_mem u_mem (
    .clk_i       (clk_i),
    .we_i        (accept && !func_i && face_ok),
    .wr_corner_i (corner_i),
    .wr_face_i   (FACE_AW'(face_i)),
    .wr_data_i   (wr_data),
    .rd_face_i   (FACE_AW'(face_i)),
    .rd_data_o   (rd_data)
  );

  // request stage, aligned with the store read
  logic   req_vld_q, req_ok_q;
  coord_t req_qx_q, req_qz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= accept && func_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_ok_q <= face_ok;
    req_qx_q <= query_x_i;
    req_qz_q <= query_z_i;
  end

  side_t    geo_side;
  tri_div_t div0, div1;

  qfhi_geom u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_vld_q),
    .face_ok_i (req_ok_q),
    .qx_i      (req_qx_q),
    .qz_i      (req_qz_q),
    .vert_i    (rd_data),
    .side_o    (geo_side),
    .div0_o    (div0),
    .div1_o    (div1)
  );

  logic [QW-1:0] q0a, q0b, q1a, q1b;

  qfhi_div u_div0a (.clk_i(clk_i), .num_i(div0.num_a), .den_i(div0.den), .quo_o(q0a));
  qfhi_div u_div0b (.clk_i(clk_i), .num_i(div0.num_b), .den_i(div0.den), .quo_o(q0b));
  qfhi_div u_div1a (.clk_i(clk_i), .num_i(div1.num_a), .den_i(div1.den), .quo_o(q1a));
  qfhi_div u_div1b (.clk_i(clk_i), .num_i(div1.num_b), .den_i(div1.den), .quo_o(q1b));

  // side data rides alongside the dividers
  side_t dly_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) begin
        dly_q[s] <= '0;
      end
    end else begin
      dly_q[0] <= geo_side;
      for (int s = 1; s < QW; s++) begin
        dly_q[s] <= dly_q[s-1];
      end
    end
  end

  qfhi_interp u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .side_i    (dly_q[QW-1]),
    .q0a_i     (q0a),
    .q0b_i     (q0b),
    .q1a_i     (q1a),
    .q1b_i     (q1b),
    .done_o    (done_o),
    .height_o  (height_o),
    .on_face_o (on_face_o)
  );

endmodule

// ===== rtl/qfhi_checker.sv =====
// Port-level checker for the quad face height interpolator, bound to the top.
// Depends on qfhi_pkg.
module qfhi_checker
  import qfhi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        func_i,
  input logic [9:0]  face_i,
  input logic [1:0]  corner_i,
  input coord_t      vert_x_i,
  input coord_t      vert_y_i,
  input coord_t      vert_z_i,
  input coord_t      query_x_i,
  input coord_t      query_z_i,
  input logic        done_o,
  input coord_t      height_o,
  input logic        on_face_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_query_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i) |-> ##LAT done_o)
    else $error("query request without result");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && func_i && rst_ni, LAT))
    else $error("result without query request");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !func_i) |-> ##LAT !done_o)
    else $error("write request produced a result");

endmodule

bind quad_face_height_interpolator qfhi_checker u_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for quad_face_height_interpolator: corner writes and height
// queries checked against a local barycentric height predictor and an in-order scoreboard.
// Depends on rtl/qfhi_pkg.sv and rtl/quad_face_height_interpolator.sv.
`timescale 1ns / 100ps

module testbench;
  import qfhi_pkg::*;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam int   RAND_ITEMS = 1600;
  localparam int   QUIET_MAX  = 3000;
  localparam longint FX_ONE   = 64'h10000;

  typedef struct packed {
    coord_t height;
    logic   on_face;
  } height_res_t;

  class height_scoreboard;
    height_res_t pending[$];
    int errors = 0;

    function void note_query(height_res_t e);
      pending.push_back(e);
    endfunction

    function void check_result(coord_t h, logic on);
      height_res_t e;
      if (pending.size() == 0) begin
        $error("result with no query outstanding: height %0d on_face %0b", h, on);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.height) begin
        $error("height: expected %0d, actual %0d", e.height, h);
        errors++;
      end
      if (on !== e.on_face) begin
        $error("on_face: expected %0b, actual %0b", e.on_face, on);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   func_i = 1'b0;
  logic [9:0] face_i = '0;
  logic [1:0] corner_i = '0;
  coord_t vert_x_i = '0, vert_y_i = '0, vert_z_i = '0;
  coord_t query_x_i = '0, query_z_i = '0;
  logic   busy_o, done_o, on_face_o;
  coord_t height_o;

  quad_face_height_interpolator i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .face_i, .corner_i,
    .vert_x_i, .vert_y_i, .vert_z_i, .query_x_i, .query_z_i,
    .done_o, .height_o, .on_face_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  height_scoreboard sb = new();

  // local copy of the corner store
  coord_t cx [FACE_COUNT*4];
  coord_t cy [FACE_COUNT*4];
  coord_t cz [FACE_COUNT*4];
  logic [3:0] written [FACE_COUNT];
  int complete_faces[$];
  int idle_pct = 0;
  int sent = 0;

  function automatic longint mulfx(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  // returns 1 when the denominator is below the minimum
  function automatic bit solve_tri(longint vx[4], longint vz[4], int o, int i, int j,
                                   longint qx, longint qz,
                                   output longint al, output longint be);
    longint ax, az, bx, bz, px, pz, num, den;
    ax = (vx[i] - vx[o]) * 256;
    az = (vz[i] - vz[o]) * 256;
    bx = (vx[j] - vx[o]) * 256;
    bz = (vz[j] - vz[o]) * 256;
    px = qx * 256 - vx[o] * 256;
    pz = qz * 256 - vz[o] * 256;
    num = mulfx(px, bz) - mulfx(pz, bx);
    den = mulfx(bz, ax) - mulfx(bx, az);
    if (den == 0) den = ZERO_BOT_SUB;
    al = (num * 65536) / den;
    be = 0;
    if (den < MIN_BOT) return 1'b1;
    num = mulfx(pz, ax) - mulfx(px, az);
    be = (num * 65536) / den;
    return 1'b0;
  endfunction

  function automatic void clamp_ab(inout longint a, inout longint b, inout logic on);
    if (a < 0) begin a = 0; on = 1'b0; end
    if (b < 0) begin b = 0; on = 1'b0; end
    if (a > FX_ONE) begin a = FX_ONE; on = 1'b0; end
    if (b > FX_ONE) begin b = FX_ONE; on = 1'b0; end
  endfunction

  function automatic coord_t blend_height(longint vy[4], int o, int i, int j,
                                          longint al, longint be);
    longint y;
    y = vy[o] * 256 + mulfx(al, (vy[i] - vy[o]) * 256) + mulfx(be, (vy[j] - vy[o]) * 256);
    y = y >>> 8;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return coord_t'(y);
  endfunction

  function automatic height_res_t face_height(int f, longint qx, longint qz);
    longint vx[4], vy[4], vz[4];
    longint sx, sz, mx, mz, al, be;
    height_res_t r;
    sx = 0;
    sz = 0;
    r.on_face = 1'b1;
    for (int c = 0; c < 4; c++) begin
      vx[c] = cx[f*4+c];
      vy[c] = cy[f*4+c];
      vz[c] = cz[f*4+c];
      sx += vx[c];
      sz += vz[c];
    end
    if (vy[0] == vy[1] && vy[1] == vy[2] && vy[2] == vy[3]) begin
      r.height = coord_t'(vy[0]);
      return r;
    end
    mx = sx >>> 2;
    mz = sz >>> 2;
    for (int c = 0; c < 4; c++) begin
      vx[c] = (((vx[c] - mx) * WIDEN_FACTOR) >>> 8) + mx;
      vz[c] = (((vz[c] - mz) * WIDEN_FACTOR) >>> 8) + mz;
    end
    if (solve_tri(vx, vz, 0, 1, 2, qx, qz, al, be)) begin
      r.height = coord_t'(vy[0]);
      return r;
    end
    clamp_ab(al, be, r.on_face);
    if (al + be <= FX_ONE) begin
      r.height = blend_height(vy, 0, 1, 2, al, be);
      return r;
    end
    if (solve_tri(vx, vz, 3, 2, 1, qx, qz, al, be)) begin
      r.height = coord_t'(vy[3]);
      return r;
    end
    clamp_ab(al, be, r.on_face);
    if (al + be > FX_ONE) begin
      r.height = coord_t'(vy[1]);
      r.on_face = 1'b0;
      return r;
    end
    r.height = blend_height(vy, 3, 2, 1, al, be);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(logic fn, int f, int cn, int x, int y, int z, int qx, int qz);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i   <= 1'b1;
    func_i    <= fn;
    face_i    <= f[9:0];
    corner_i  <= cn[1:0];
    vert_x_i  <= coord_t'(x);
    vert_y_i  <= coord_t'(y);
    vert_z_i  <= coord_t'(z);
    query_x_i <= coord_t'(qx);
    query_z_i <= coord_t'(qz);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (fn == FUNC_WRITE) begin
      cx[f*4+cn] = coord_t'(x);
      cy[f*4+cn] = coord_t'(y);
      cz[f*4+cn] = coord_t'(z);
      if (written[f] != 4'hf) begin
        written[f][cn] = 1'b1;
        if (written[f] == 4'hf) complete_faces.push_back(f);
      end
    end else begin
      sb.note_query(face_height(f, coord_t'(qx), coord_t'(qz)));
    end
    sent++;
    @(negedge clk_i);
  endtask

  task automatic write_corner(int f, int cn, int x, int y, int z);
    send(FUNC_WRITE, f, cn, x, y, z, $urandom, $urandom);
  endtask

  task automatic ask(int f, int qx, int qz);
    send(FUNC_QUERY, f, $urandom, $urandom, $urandom, $urandom, qx, qz);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // writes a roughly quadrilateral face around a random spot
  task automatic build_face;
    int f, span, bx, bz, hs, px[4], pz[4], t;
    f = $urandom_range(0, FACE_COUNT - 1);
    case ($urandom_range(0, 9))
      0:       span = $urandom_range(1, 8);
      1:       span = $urandom_range(20000, 32767);
      default: span = $urandom_range(64, 4000);
    endcase
    bx = $urandom_range(0, 65535) - 32768;
    bz = $urandom_range(0, 65535) - 32768;
    hs = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 2000);
    for (int c = 0; c < 4; c++) begin
      px[c] = bx + ((c & 1) ? span : 0) + $urandom_range(0, span / 4);
      pz[c] = bz + ((c & 2) ? span : 0) + $urandom_range(0, span / 4);
    end
    // clockwise order now and then
    if ($urandom_range(0, 5) == 0) begin
      t = px[1]; px[1] = px[2]; px[2] = t;
      t = pz[1]; pz[1] = pz[2]; pz[2] = t;
    end
    t = $urandom_range(0, 65535) - 32768;
    for (int c = 0; c < 4; c++)
      write_corner(f, c, px[c], ($urandom_range(0, 6) == 0) ? t
                   : t + $urandom_range(0, hs) - hs / 2, pz[c]);
  endtask

  task automatic random_query;
    int f, k, mx, mz, r;
    k = complete_faces[$urandom_range(0, complete_faces.size() - 1)];
    f = k;
    mx = 0;
    mz = 0;
    r = 0;
    for (int c = 0; c < 4; c++) begin
      mx += cx[f*4+c];
      mz += cz[f*4+c];
      if ((cx[f*4+c] - cx[f*4]) > r) r = cx[f*4+c] - cx[f*4];
      if ((cx[f*4] - cx[f*4+c]) > r) r = cx[f*4] - cx[f*4+c];
    end
    mx = mx / 4;
    mz = mz / 4;
    r = r + 2;
    if ($urandom_range(0, 9) == 0)
      ask(f, $urandom, $urandom);
    else
      ask(f, mx + $urandom_range(0, 2 * r) - r, mz + $urandom_range(0, 2 * r) - r);
  endtask

  always @(posedge clk_i)
    if (rst_ni && done_o) sb.check_result(height_o, on_face_o);

  int quiet = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("quad_face_height_interpolator verification failed");
      $finish;
    end
  end

  initial begin
    for (int f = 0; f < FACE_COUNT; f++) written[f] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain face, both triangles, clamping and a point off the face
    write_corner(0, 0, 0, 0, 0);
    write_corner(0, 1, 1000, 100, 0);
    write_corner(0, 2, 0, 200, 1000);
    write_corner(0, 3, 1000, 300, 1000);
    ask(0, 100, 100);
    ask(0, 900, 900);
    ask(0, -500, 300);
    ask(0, 32767, -32768);
    // clockwise winding: small denominator
    write_corner(0, 1, 0, 100, 1000);
    write_corner(0, 2, 1000, 200, 0);
    ask(0, 500, 500);
    // flat face at extreme coordinates
    write_corner(1023, 0, -32768, -32768, -32768);
    write_corner(1023, 1, 32767, -32768, -32768);
    write_corner(1023, 2, -32768, -32768, 32767);
    write_corner(1023, 3, 32767, -32768, 32767);
    ask(1023, 0, 0);
    // collapsed footprint (zero denominator), then saturating heights
    write_corner(1023, 1, -32768, 32767, -32768);
    write_corner(1023, 2, -32768, 32767, -32768);
    write_corner(1023, 3, -32768, -32768, -32768);
    ask(1023, -32768, -32768);
    write_corner(1023, 1, 32767, 32767, -32768);
    write_corner(1023, 2, -32768, 32767, 32767);
    ask(1023, 30000, 30000);
    ask(1023, -30000, 0);
    drain();

    while (sent < RAND_ITEMS + 25) begin
      if (sent > 560 && idle_pct == 14 && sent < 1100) begin
        drain();
        idle_pct = 60;
      end else if (sent >= 1100 && idle_pct == 60) begin
        drain();
        idle_pct = 0;
      end else if (sent <= 560 && idle_pct == 0) begin
        idle_pct = 14;
      end
      case ($urandom_range(0, 19))
        0, 1, 2: build_face();
        3: if (complete_faces.size() != 0) begin
          // rewrite one corner of a finished face with anything
          write_corner(complete_faces[$urandom_range(0, complete_faces.size() - 1)],
                       $urandom_range(0, 3), $urandom, $urandom, $urandom);
        end else begin
          build_face();
        end
        default: if (complete_faces.size() != 0) random_query(); else build_face();
      endcase
      if (sent < 700 && idle_pct == 60) idle_pct = 60;
    end

    drain();
    repeat (LAT + 20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("quad_face_height_interpolator verification clean");
    end else begin
      $display("quad_face_height_interpolator verification failed");
    end
    $finish;
  end

endmodule
